// ----- rtl/lgd_pkg.sv -----
package lgd_pkg;

  // Defaults for the top-level parameters
  localparam int FLOOR_COUNT_DEF = 16;
  localparam int LIFT_COUNT_DEF  = 8;
  localparam int TIME_BITS_DEF   = 20;

  // Fixed field widths of the request, the result and the register file
  localparam int FIELD_TIME_W  = 20;
  localparam int FIELD_FLOOR_W = 5;
  localparam int SECONDS_W     = 8;
  localparam int INDEX_W       = 3;
  localparam int COUNT_W       = 16;
  localparam int DED_W         = 4;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;

  // Register file map (word index = paddr[4:2])
  localparam logic [2:0] REG_DISPATCH_MODE   = 3'd0;
  localparam logic [2:0] REG_ZONE_FLOOR      = 3'd1;
  localparam logic [2:0] REG_DEDICATED_LIFTS = 3'd2;
  localparam logic [2:0] REG_WINDOW_START    = 3'd3;
  localparam logic [2:0] REG_WINDOW_END      = 3'd4;
  localparam logic [2:0] REG_FLOOR_SECONDS   = 3'd5;
  localparam logic [2:0] REG_STOP_SECONDS    = 3'd6;

  localparam logic                     MODE_ROTATION = 1'b0;
  localparam logic                     MODE_COST     = 1'b1;
  localparam logic [FIELD_FLOOR_W-1:0] ZONE_FLOOR_RST   = 5'd1;
  localparam logic [DED_W-1:0]         DEDICATED_RST    = 4'd2;
  localparam logic [FIELD_TIME_W-1:0]  WINDOW_START_RST = 20'd14400;
  localparam logic [FIELD_TIME_W-1:0]  WINDOW_END_RST   = 20'd18000;
  localparam logic [SECONDS_W-1:0]     FLOOR_SEC_RST    = 8'd3;
  localparam logic [SECONDS_W-1:0]     STOP_SEC_RST     = 8'd8;

endpackage

// ----- rtl/lgd_cost_unit.sv -----
module lgd_cost_unit import lgd_pkg::*; #(
  parameter int FLOOR_W = 5,
  parameter int COST_W  = 22
) (
  input  logic [COST_W-1:0]    free_i,
  input  logic [COST_W-1:0]    arrival_i,
  input  logic [FLOOR_W-1:0]   floor_a_i,
  input  logic [FLOOR_W-1:0]   floor_b_i,
  input  logic [SECONDS_W-1:0] floor_seconds_i,
  input  logic [SECONDS_W:0]   extra_i,
  output logic [COST_W-1:0]    cost_o
);

  logic [FLOOR_W-1:0]           floor_gap;
  logic [FLOOR_W+SECONDS_W-1:0] travel;
  logic [COST_W-1:0]            ready;

  assign floor_gap = (floor_a_i > floor_b_i) ? floor_a_i - floor_b_i : floor_b_i - floor_a_i;
  assign travel = {{SECONDS_W{1'b0}}, floor_gap} * {{FLOOR_W{1'b0}}, floor_seconds_i};
  assign ready  = (free_i > arrival_i) ? free_i : arrival_i;
  assign cost_o = ready + COST_W'(travel) + COST_W'(extra_i);

endmodule

// ----- rtl/lift_group_dispatcher.sv -----
// Sequence: cost mode scans the lifts after the accepting edge (one lift scored per cycle by
// the shared cost unit), then forms pickup and drop-off on the same unit; rotation mode goes
// straight to pickup and drop-off. done_o is high in the cycle after the drop state.
// A new request is taken only when idle, so not before the last result is shown;
// busy is high from acceptance until the result is shown, and the receiver cannot stall.
// Reset: lifts at floor 1 and free at 0, counters and rotation cleared, registers at defaults.
module lift_group_dispatcher import lgd_pkg::*; #(
  parameter int FLOOR_COUNT = FLOOR_COUNT_DEF,
  parameter int LIFT_COUNT  = LIFT_COUNT_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic                     new_run_i,
  input  logic [FIELD_TIME_W-1:0]  arrival_time_i,
  input  logic [FIELD_FLOOR_W-1:0] origin_floor_i,
  input  logic [FIELD_FLOOR_W-1:0] target_floor_i,
  output logic                     done_o,
  output logic                     served_o,
  output logic [INDEX_W-1:0]       lift_index_o,
  output logic [FIELD_TIME_W-1:0]  pickup_time_o,
  output logic [FIELD_TIME_W-1:0]  dropoff_time_o,
  output logic [FIELD_TIME_W-1:0]  wait_seconds_o,
  output logic [COUNT_W-1:0]       peak_unserved_o
);

  localparam int FLOOR_W = $clog2(FLOOR_COUNT + 1);
  localparam int LIFT_W  = (LIFT_COUNT > 1) ? $clog2(LIFT_COUNT) : 1;
  localparam int BASE_W  = (TIME_BITS > FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
  localparam int COST_W  = BASE_W + 2;

  localparam logic [LIFT_W-1:0] LAST_LIFT = LIFT_W'(LIFT_COUNT - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_DROP = 2'd3;

  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FIELD_FLOOR_W-1:0] f);
    if (f == '0) begin
      return FLOOR_W'(1);
    end else if (int'(f) > FLOOR_COUNT) begin
      return FLOOR_W'(FLOOR_COUNT);
    end else begin
      return FLOOR_W'(f);
    end
  endfunction

  // Register file
  logic                     mode_q;
  logic [FIELD_FLOOR_W-1:0] zone_floor_q;
  logic [DED_W-1:0]         dedicated_q;
  logic [FIELD_TIME_W-1:0]  window_start_q;
  logic [FIELD_TIME_W-1:0]  window_end_q;
  logic [SECONDS_W-1:0]     floor_sec_q;
  logic [SECONDS_W-1:0]     stop_sec_q;

  // Lift state
  logic [FLOOR_W-1:0]   lift_floor_q [LIFT_COUNT];
  logic [TIME_BITS-1:0] lift_free_q  [LIFT_COUNT];
  logic [LIFT_W-1:0]    rotation_q;
  logic [COUNT_W-1:0]   unserved_q;
  logic [COUNT_W-1:0]   peak_q;

  // Sequencer and request context
  logic [1:0]         state_q;
  logic [LIFT_W-1:0]  idx_q;
  logic [LIFT_W-1:0]  pick_q;
  logic [COST_W-1:0]  best_q;
  logic [COST_W-1:0]  pickup_q;
  logic [COST_W-1:0]  arrival_q;
  logic [FLOOR_W-1:0] origin_q;
  logic [FLOOR_W-1:0] target_q;
  logic               zoning_q;
  logic               zone_req_q;

  // Result registers
  logic                    done_q;
  logic                    served_q;
  logic [INDEX_W-1:0]      res_lift_q;
  logic [FIELD_TIME_W-1:0] res_pickup_q;
  logic [FIELD_TIME_W-1:0] res_dropoff_q;
  logic [FIELD_TIME_W-1:0] res_wait_q;

  logic                    cfg_we;
  logic [2:0]              cfg_idx;
  logic                    accept;
  logic [FLOOR_W-1:0]      origin_c;
  logic [FLOOR_W-1:0]      target_c;
  logic                    zoning_d;
  logic                    zone_req_d;
  logic [LIFT_W-1:0]       rotation_cur;
  logic [LIFT_W-1:0]       rd_idx;
  logic                    penalty;
  logic [COST_W-1:0]       unit_free;
  logic [COST_W-1:0]       unit_arrival;
  logic [FLOOR_W-1:0]      unit_floor_a;
  logic [FLOOR_W-1:0]      unit_floor_b;
  logic [SECONDS_W:0]      unit_extra;
  logic [COST_W-1:0]       unit_cost;
  logic                    overflow;
  logic [COUNT_W-1:0]      unserved_up;
  logic [COST_W-1:0]       wait_full;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      REG_DISPATCH_MODE:   prdata = APB_DATA_W'(mode_q);
      REG_ZONE_FLOOR:      prdata = APB_DATA_W'(zone_floor_q);
      REG_DEDICATED_LIFTS: prdata = APB_DATA_W'(dedicated_q);
      REG_WINDOW_START:    prdata = APB_DATA_W'(window_start_q);
      REG_WINDOW_END:      prdata = APB_DATA_W'(window_end_q);
      REG_FLOOR_SECONDS:   prdata = APB_DATA_W'(floor_sec_q);
      REG_STOP_SECONDS:    prdata = APB_DATA_W'(stop_sec_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_COST;
      zone_floor_q   <= ZONE_FLOOR_RST;
      dedicated_q    <= DEDICATED_RST;
      window_start_q <= WINDOW_START_RST;
      window_end_q   <= WINDOW_END_RST;
      floor_sec_q    <= FLOOR_SEC_RST;
      stop_sec_q     <= STOP_SEC_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DISPATCH_MODE:   mode_q         <= pwdata[0];
        REG_ZONE_FLOOR:      zone_floor_q   <= pwdata[FIELD_FLOOR_W-1:0];
        REG_DEDICATED_LIFTS: dedicated_q    <= pwdata[DED_W-1:0];
        REG_WINDOW_START:    window_start_q <= pwdata[FIELD_TIME_W-1:0];
        REG_WINDOW_END:      window_end_q   <= pwdata[FIELD_TIME_W-1:0];
        REG_FLOOR_SECONDS:   floor_sec_q    <= pwdata[SECONDS_W-1:0];
        REG_STOP_SECONDS:    stop_sec_q     <= pwdata[SECONDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode
  assign busy         = (state_q != S_IDLE);
  assign accept       = start & ~busy;
  assign origin_c     = clamp_floor(origin_floor_i);
  assign target_c     = clamp_floor(target_floor_i);
  assign zoning_d     = (arrival_time_i >= window_start_q) && (arrival_time_i < window_end_q)
                        && (dedicated_q != '0) && (int'(dedicated_q) < LIFT_COUNT);
  assign zone_req_d   = (int'(zone_floor_q) == int'(origin_c))
                        || (int'(zone_floor_q) == int'(target_c));
  assign rotation_cur = new_run_i ? '0 : rotation_q;

  // Shared cost unit: scores lifts during the scan, then forms pickup and drop-off
  assign rd_idx  = (state_q == S_SCAN) ? idx_q : pick_q;
  assign penalty = zoning_q && (zone_req_q != (int'(idx_q) < int'(dedicated_q)));

  always_comb begin
    unit_free    = COST_W'(lift_free_q[rd_idx]);
    unit_arrival = arrival_q;
    unit_floor_a = lift_floor_q[rd_idx];
    unit_floor_b = origin_q;
    unit_extra   = {1'b0, stop_sec_q};
    case (state_q)
      S_SCAN: begin
        unit_extra = penalty ? ({1'b0, stop_sec_q} + {1'b0, floor_sec_q}) : '0;
      end
      S_DROP: begin
        unit_free    = pickup_q;
        unit_arrival = '0;
        unit_floor_a = origin_q;
        unit_floor_b = target_q;
      end
      default: ;
    endcase
  end

  lgd_cost_unit #(
    .FLOOR_W (FLOOR_W),
    .COST_W  (COST_W)
  ) u_cost (
    .free_i          (unit_free),
    .arrival_i       (unit_arrival),
    .floor_a_i       (unit_floor_a),
    .floor_b_i       (unit_floor_b),
    .floor_seconds_i (floor_sec_q),
    .extra_i         (unit_extra),
    .cost_o          (unit_cost)
  );

  // Drop-off never precedes pickup, so one range check on drop-off covers both
  assign overflow    = |unit_cost[COST_W-1:TIME_BITS];
  assign unserved_up = (unserved_q == '1) ? unserved_q : unserved_q + COUNT_W'(1);
  assign wait_full   = pickup_q - arrival_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      pick_q        <= '0;
      best_q        <= '0;
      pickup_q      <= '0;
      arrival_q     <= '0;
      origin_q      <= '0;
      target_q      <= '0;
      zoning_q      <= 1'b0;
      zone_req_q    <= 1'b0;
      rotation_q    <= '0;
      unserved_q    <= '0;
      peak_q        <= '0;
      done_q        <= 1'b0;
      served_q      <= 1'b0;
      res_lift_q    <= '0;
      res_pickup_q  <= '0;
      res_dropoff_q <= '0;
      res_wait_q    <= '0;
      for (int i = 0; i < LIFT_COUNT; i++) begin
        lift_floor_q[i] <= FLOOR_W'(1);
        lift_free_q[i]  <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            arrival_q  <= COST_W'(arrival_time_i);
            origin_q   <= origin_c;
            target_q   <= target_c;
            zoning_q   <= zoning_d;
            zone_req_q <= zone_req_d;
            idx_q      <= '0;
            if (new_run_i) begin
              for (int i = 0; i < LIFT_COUNT; i++) begin
                lift_floor_q[i] <= FLOOR_W'(1);
                lift_free_q[i]  <= '0;
              end
              unserved_q <= '0;
              peak_q     <= '0;
            end
            if (mode_q == MODE_ROTATION) begin
              pick_q     <= rotation_cur;
              rotation_q <= (rotation_cur == LAST_LIFT) ? '0 : rotation_cur + LIFT_W'(1);
              state_q    <= S_PICK;
            end else begin
              rotation_q <= rotation_cur;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Strictly lower cost wins, so ties keep the lower index
          if (idx_q == '0 || unit_cost < best_q) begin
            best_q <= unit_cost;
            pick_q <= idx_q;
          end
          if (idx_q == LAST_LIFT) begin
            state_q <= S_PICK;
          end else begin
            idx_q <= idx_q + LIFT_W'(1);
          end
        end
        S_PICK: begin
          pickup_q <= unit_cost;
          state_q  <= S_DROP;
        end
        S_DROP: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (overflow) begin
            served_q      <= 1'b0;
            res_lift_q    <= '0;
            res_pickup_q  <= '0;
            res_dropoff_q <= '0;
            res_wait_q    <= '0;
            unserved_q    <= unserved_up;
            if (unserved_up > peak_q) begin
              peak_q <= unserved_up;
            end
          end else begin
            served_q             <= 1'b1;
            res_lift_q           <= INDEX_W'(pick_q);
            res_pickup_q         <= pickup_q[FIELD_TIME_W-1:0];
            res_dropoff_q        <= unit_cost[FIELD_TIME_W-1:0];
            res_wait_q           <= wait_full[FIELD_TIME_W-1:0];
            lift_free_q[pick_q]  <= unit_cost[TIME_BITS-1:0];
            lift_floor_q[pick_q] <= target_q;
            if (unserved_q != '0) begin
              unserved_q <= unserved_q - COUNT_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign served_o        = served_q;
  assign lift_index_o    = res_lift_q;
  assign pickup_time_o   = res_pickup_q;
  assign dropoff_time_o  = res_dropoff_q;
  assign wait_seconds_o  = res_wait_q;
  assign peak_unserved_o = peak_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("transaction left busy without a result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !served_o) |-> (lift_index_o == '0 && pickup_time_o == '0
                               && dropoff_time_o == '0 && wait_seconds_o == '0))
    else $error("rejected transaction carries nonzero result fields");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (int'(idx_q) < LIFT_COUNT))
    else $error("scan index past last lift");

endmodule
